>>> sv/bfp_pkg.sv
// ----------------------------------------------------------------------------
// bfp_pkg: shared types and constants for the BCD fixed-point power block
// Holds the fixed field sizes, the command/status bundles between the
// controller and the datapath, and the exponent clamp.
// ----------------------------------------------------------------------------
package bfp_pkg;

   localparam int BASE_DIGITS  = 5;
   localparam int MAX_EXPONENT = 25;
   localparam int GROUP_SIZE   = 16;
   localparam int PRINT_MAX    = 128;
   localparam int LEN_W        = 9;   // holds any digit count up to 256
   localparam int PCNT_W       = 7;   // counts printed digits below PRINT_MAX
   localparam int EXP_W        = 5;
   localparam int BIN_W        = 17;  // binary form of a five-digit base

   typedef struct packed {
      logic mul_start;
      logic print_start;
   } cmd_type;

   typedef struct packed {
      logic pass_done;
      logic print_done;
   } sts_type;

   // zero counts as one, large values clamp
   function automatic logic [EXP_W-1:0] sat_exponent(input logic [EXP_W-1:0] ex);
      logic [EXP_W-1:0] r;
      r = ex;
      if (ex == '0) r = EXP_W'(1);
      if (ex > EXP_W'(MAX_EXPONENT)) r = EXP_W'(MAX_EXPONENT);
      return r;
   endfunction

endpackage

>>> sv/bcd_fixed_point_power.sv
// ----------------------------------------------------------------------------
// bcd_fixed_point_power: exact decimal power of a five-digit BCD base
// Usage: present base, point position and exponent with req_start while
// busy is low; the beat is taken at that edge. The block fills its product
// memory, then runs exponent-1 multiply passes, each walking every product
// digit once through a two-stage multiply/carry pipeline via the single
// memory read port, then prints about one digit per cycle.
// Results leave as beats of up to 16 digits on rsp_*, each marked by a
// one-cycle rsp_valid; rsp_last flags the final beat. The receiver cannot
// stall, so beats go out as soon as they are packed.
// One item is in flight at a time; busy stays high until the last digit
// is packed. A zero result is a single beat holding 0.
// Reset (synchronous, active high) returns the sequencer to idle; the
// product memory is not cleared since each item overwrites it fully.
// ----------------------------------------------------------------------------
module bcd_fixed_point_power #(
   parameter int MAX_DIGITS = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   input  logic [19:0] req_base_bcd,
   input  logic [2:0]  req_point_pos,
   input  logic [4:0]  req_exponent,
   output logic        busy,
   output logic        rsp_valid,
   output logic [63:0] rsp_digit_group,
   output logic [4:0]  rsp_group_digits,
   output logic [4:0]  rsp_point_index,
   output logic        rsp_last
);
   import bfp_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    load;

   assign load = req_start && !busy;

   bfp_controller u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .req_exponent(req_exponent),
      .sts         (sts),
      .cmd         (cmd),
      .busy        (busy)
   );

   bfp_datapath #(.MAX_DIGITS(MAX_DIGITS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .req_base_bcd    (req_base_bcd),
      .req_point_pos   (req_point_pos),
      .req_exponent    (req_exponent),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_digit_group (rsp_digit_group),
      .rsp_group_digits(rsp_group_digits),
      .rsp_point_index (rsp_point_index),
      .rsp_last        (rsp_last)
   );
endmodule

>>> sv/bfp_ram.sv
// ----------------------------------------------------------------------------
// bfp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bfp_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> sv/bfp_datapath.sv
// ----------------------------------------------------------------------------
// bfp_datapath: product memory, digit-serial multiplier and printer
// Walks the product one digit a cycle multiplying by the binary base with a
// running carry, tracks the highest and lowest nonzero digit, then reads the
// digits back most significant first and packs them into groups.
// ----------------------------------------------------------------------------
module bfp_datapath #(
   parameter int MAX_DIGITS = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [19:0]           req_base_bcd,
   input  logic [2:0]            req_point_pos,
   input  logic [4:0]            req_exponent,
   input  bfp_pkg::cmd_type      cmd,
   output bfp_pkg::sts_type      sts,
   output logic                  rsp_valid,
   output logic [63:0]           rsp_digit_group,
   output logic [4:0]            rsp_group_digits,
   output logic [4:0]            rsp_point_index,
   output logic                  rsp_last
);
   import bfp_pkg::*;

   localparam int AW = $clog2(MAX_DIGITS);
   localparam logic [LEN_W-1:0] LAST_IDX = LEN_W'(MAX_DIGITS - 1);

   // operand registers
   logic [3:0]       mult_ff [8];
   logic [BIN_W-1:0] b_ff;
   logic [7:0]       frac_ff;

   // walk control
   logic             run_ff, init_ff;
   logic [LEN_W-1:0] j_ff;
   logic             s1_v_ff, s2_v_ff;
   logic [AW-1:0]    s1_idx_ff, s2_idx_ff;
   logic [19:0]      prod_ff;
   logic [16:0]      carry_ff;

   // nonzero tracking
   logic [LEN_W-1:0] hi_ff, lo_ff;
   logic             lo_found_ff;

   // printer
   logic             pr_run_ff, has_frac_ff, zero_done_ff;
   logic [LEN_W-1:0] cur_ff, end_ff;
   logic [PCNT_W-1:0] emit_cnt_ff;
   logic             t_v_ff, t_last_ff, t_pt_ff, t_oob_ff;
   logic [59:0]      grp_ff;
   logic [4:0]       gcnt_ff, gpt_ff;

   // result registers
   logic             rsp_valid_ff, rsp_last_ff;
   logic [63:0]      rsp_group_ff;
   logic [4:0]       rsp_cnt_ff, rsp_pt_ff;

   // memory ports
   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [3:0]       wr_data, rd_data;

   bfp_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_prod_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // input decode: saturate digits, form binary base and point count
   logic [3:0]       dig_in [8];
   logic [BIN_W-1:0] b_in;
   logic [2:0]       pos_sat;
   logic [EXP_W-1:0] ex_sat;
   logic [7:0]       frac_in;
   always_comb begin
      b_in = '0;
      for (int i = 0; i < 8; i++) dig_in[i] = 4'd0;
      for (int i = 0; i < BASE_DIGITS; i++) begin
         dig_in[i] = req_base_bcd[4*i +: 4];
         if (dig_in[i] > 4'd9) dig_in[i] = 4'd9;
      end
      for (int i = BASE_DIGITS - 1; i >= 0; i--)
         b_in = BIN_W'(b_in * BIN_W'(10)) + BIN_W'(dig_in[i]);
      pos_sat = (req_point_pos > 3'(BASE_DIGITS)) ? 3'(BASE_DIGITS) : req_point_pos;
      ex_sat  = sat_exponent(req_exponent);
      frac_in = 8'(pos_sat) * 8'(ex_sat);
   end

   // carry stage: acc = prod + carry, split by ten via reciprocal
   logic [19:0] acc;
   logic [51:0] recip;
   logic [19:0] quo;
   logic [3:0]  rem;
   always_comb begin
      acc   = prod_ff + 20'(carry_ff);
      recip = 52'(acc) * 52'd429496730;
      quo   = recip[51:32];
      rem   = 4'(acc - 20'(quo * 20'd10));
   end

   // write port: fill pass or carry stage
   always_comb begin
      if (run_ff && init_ff) begin
         wr_en   = 1'b1;
         wr_addr = j_ff[AW-1:0];
         wr_data = (j_ff < LEN_W'(8)) ? mult_ff[j_ff[2:0]] : 4'd0;
      end else begin
         wr_en   = s2_v_ff;
         wr_addr = s2_idx_ff;
         wr_data = rem;
      end
      rd_addr = pr_run_ff ? cur_ff[AW-1:0] : j_ff[AW-1:0];
   end

   // status to the controller
   always_comb begin
      sts.pass_done  = (run_ff && init_ff && j_ff == LAST_IDX) ||
                       (s2_v_ff && s2_idx_ff == AW'(MAX_DIGITS - 1));
      sts.print_done = (t_v_ff && t_last_ff) || zero_done_ff;
   end

   // print setup values
   logic [LEN_W-1:0] frac9, splus;
   logic             has_frac, is_zero;
   always_comb begin
      frac9    = LEN_W'(frac_ff);
      has_frac = lo_found_ff && (lo_ff < frac9);
      splus    = (hi_ff > frac9) ? hi_ff : frac9;
      is_zero  = !(hi_ff > frac9) && !has_frac;
   end

   // group append
   logic [3:0] app_d;
   logic [4:0] app_cnt;
   assign app_d   = t_oob_ff ? 4'd0 : rd_data;
   assign app_cnt = gcnt_ff + 5'd1;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         init_ff      <= 1'b0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         pr_run_ff    <= 1'b0;
         t_v_ff       <= 1'b0;
         zero_done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lo_found_ff  <= 1'b0;
      end else begin
         zero_done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         s1_v_ff      <= run_ff && !init_ff;
         s2_v_ff      <= s1_v_ff;
         if (run_ff && j_ff == LAST_IDX) run_ff <= 1'b0;
         if (load || cmd.mul_start) begin
            run_ff      <= 1'b1;
            init_ff     <= load;
            lo_found_ff <= 1'b0;
         end
         if (wr_en && wr_data != 4'd0 && !lo_found_ff) lo_found_ff <= 1'b1;
         // printer issue
         t_v_ff <= pr_run_ff;
         if (pr_run_ff && (cur_ff == end_ff || emit_cnt_ff == PCNT_W'(PRINT_MAX - 1)))
            pr_run_ff <= 1'b0;
         if (cmd.print_start) begin
            if (is_zero) begin
               zero_done_ff <= 1'b1;
               rsp_valid_ff <= 1'b1;
            end else begin
               pr_run_ff <= 1'b1;
            end
         end
         if (t_v_ff && (app_cnt == 5'(GROUP_SIZE) || t_last_ff)) rsp_valid_ff <= 1'b1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < 8; i++) mult_ff[i] <= dig_in[i];
         b_ff    <= b_in;
         frac_ff <= frac_in;
      end
      // walk
      if (run_ff) j_ff <= j_ff + LEN_W'(1);
      if (load || cmd.mul_start) begin
         j_ff     <= '0;
         carry_ff <= '0;
         hi_ff    <= '0;
         lo_ff    <= '0;
      end
      s1_idx_ff <= j_ff[AW-1:0];
      s2_idx_ff <= s1_idx_ff;
      prod_ff   <= 20'(21'(rd_data) * 21'(b_ff));
      if (s2_v_ff) carry_ff <= quo[16:0];
      // nonzero tracking
      if (wr_en && wr_data != 4'd0) begin
         hi_ff <= LEN_W'(wr_addr) + LEN_W'(1);
         if (!lo_found_ff) lo_ff <= LEN_W'(wr_addr);
      end
      // printer setup and issue
      if (cmd.print_start) begin
         cur_ff      <= splus - LEN_W'(1);
         end_ff      <= has_frac ? lo_ff : frac9;
         has_frac_ff <= has_frac;
         emit_cnt_ff <= '0;
         grp_ff      <= '0;
         gcnt_ff     <= '0;
         gpt_ff      <= 5'd16;
         if (is_zero) begin
            rsp_group_ff <= '0;
            rsp_cnt_ff   <= 5'd1;
            rsp_pt_ff    <= 5'd16;
            rsp_last_ff  <= 1'b1;
         end
      end
      if (pr_run_ff) begin
         cur_ff      <= cur_ff - LEN_W'(1);
         emit_cnt_ff <= emit_cnt_ff + PCNT_W'(1);
      end
      t_last_ff <= (cur_ff == end_ff) || (emit_cnt_ff == PCNT_W'(PRINT_MAX - 1));
      t_pt_ff   <= has_frac_ff && (cur_ff == frac9 - LEN_W'(1));
      t_oob_ff  <= cur_ff >= LEN_W'(MAX_DIGITS);
      // group packing
      if (t_v_ff) begin
         if (app_cnt == 5'(GROUP_SIZE) || t_last_ff) begin
            rsp_group_ff <= {grp_ff, app_d};
            rsp_cnt_ff   <= app_cnt;
            rsp_pt_ff    <= t_pt_ff ? gcnt_ff : gpt_ff;
            rsp_last_ff  <= t_last_ff;
            grp_ff       <= '0;
            gcnt_ff      <= '0;
            gpt_ff       <= 5'd16;
         end else begin
            grp_ff  <= {grp_ff[55:0], app_d};
            gcnt_ff <= app_cnt;
            if (t_pt_ff) gpt_ff <= gcnt_ff;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_digit_group  = rsp_group_ff;
   assign rsp_group_digits = rsp_cnt_ff;
   assign rsp_point_index  = rsp_pt_ff;
   assign rsp_last         = rsp_last_ff;
endmodule

>>> sv/bfp_controller.sv
// ----------------------------------------------------------------------------
// bfp_controller: sequencer for fill, multiply passes and printing
// Counts the remaining multiplications and steps the datapath through them.
// ----------------------------------------------------------------------------
module bfp_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  logic [4:0]                req_exponent,
   input  bfp_pkg::sts_type          sts,
   output bfp_pkg::cmd_type          cmd,
   output logic                      busy
);
   import bfp_pkg::*;

   typedef enum logic [1:0] {IDLE, FILL, MULT, PRINT} state_type;

   state_type        state_ff;
   cmd_type          cmd_ff;
   logic [EXP_W-1:0] mul_left_ff;

   // state, command pulses and pass count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= IDLE;
         cmd_ff      <= '0;
         mul_left_ff <= '0;
      end else begin
         cmd_ff <= '0;
         case (state_ff)
            IDLE: begin
               if (load) begin
                  mul_left_ff <= sat_exponent(req_exponent) - EXP_W'(1);
                  state_ff    <= FILL;
               end
            end
            FILL, MULT: begin
               if (sts.pass_done) begin
                  if (mul_left_ff == '0) begin
                     cmd_ff.print_start <= 1'b1;
                     state_ff           <= PRINT;
                  end else begin
                     cmd_ff.mul_start <= 1'b1;
                     mul_left_ff      <= mul_left_ff - EXP_W'(1);
                     state_ff         <= MULT;
                  end
               end
            end
            PRINT: begin
               if (sts.print_done) state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign cmd  = cmd_ff;
   assign busy = (state_ff != IDLE);
endmodule
